// ----- src/pru_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_pkg
// Shared constants, register codes and inter-module records for the
// pixel replicate upscaler.
// ----------------------------------------------------------------------------
package pru_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_SCALE  = 16;

  localparam int COLOR_W    = 8;
  localparam int PIX_W      = 3 * COLOR_W;
  localparam int SCALE_W    = 5;
  localparam int WIDTH_W    = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int PAD_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE = 1'b0,
    REG_WIDTH = 1'b1
  } cfg_reg_t;

  // decoded item handed from the sequencer to the emitter
  typedef struct packed {
    logic             err;
    logic             use_mem;
    logic             row_done;
    logic [PAD_W-1:0] pad;
    logic [PIX_W-1:0] rgb;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] rgb;
    logic             row_end;
    logic             error;
    logic             last;
  } result_t;

endpackage

// ----- src/pru_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_if
// Valid/ready stream interfaces for the upscaler input items and results.
// ----------------------------------------------------------------------------
interface pru_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [pru_pkg::COLOR_W-1:0] red;
  logic [pru_pkg::COLOR_W-1:0] green;
  logic [pru_pkg::COLOR_W-1:0] blue;

  modport source (output valid, func, red, green, blue, input ready);
  modport sink   (input valid, func, red, green, blue, output ready);
endinterface

interface pru_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [pru_pkg::COLOR_W-1:0] out_red;
  logic [pru_pkg::COLOR_W-1:0] out_green;
  logic [pru_pkg::COLOR_W-1:0] out_blue;
  logic                       row_end;
  logic                       error;
  logic                       last;

  modport source (output valid, kind, out_red, out_green, out_blue, row_end, error, last,
                  input ready);
  modport sink   (input valid, kind, out_red, out_green, out_blue, row_end, error, last,
                  output ready);
endinterface

// ----- src/pru_line_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_line_store
// Single-port line memory, one source row of pixels, registered read.
// ----------------------------------------------------------------------------
module pru_line_store #(
  parameter int DEPTH = pru_pkg::MAX_WIDTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic                      re,
  input  logic [AW-1:0]             addr,
  input  logic [pru_pkg::PIX_W-1:0] wdata,
  output logic [pru_pkg::PIX_W-1:0] rdata
);

  logic [pru_pkg::PIX_W-1:0] mem [DEPTH];
  logic [pru_pkg::PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/pru_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_ctrl
// Configuration registers and row sequencer: checks item order, tracks
// column / repeat / phase, drives the line store and issues commands.
// ----------------------------------------------------------------------------
module pru_ctrl #(
  parameter int MAX_WIDTH = pru_pkg::MAX_WIDTH,
  parameter int MAX_SCALE = pru_pkg::MAX_SCALE,
  parameter int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  parameter int SW        = $clog2(MAX_SCALE + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pru_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [pru_pkg::PIX_W-1:0]      in_rgb,
  output logic                           mem_we,
  output logic                           mem_re,
  output logic [CW-1:0]                  mem_addr,
  output logic [pru_pkg::PIX_W-1:0]      mem_wdata,
  output logic [SW-1:0]                  scale_cnt,
  output logic                           cmd_v,
  output pru_pkg::cmd_t                  cmd,
  input  logic                           cmd_take
);

  localparam int RW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  logic [pru_pkg::SCALE_W-1:0] scale_r;
  logic [pru_pkg::WIDTH_W-1:0] width_r;
  logic [CW-1:0]               column_r, column_nxt;
  logic [RW-1:0]               rep_r, rep_nxt;
  logic                        phase_r, phase_nxt;
  logic                        cmd_v_r, cmd_v_nxt;
  pru_pkg::cmd_t               cmd_r;

  logic [31:0]                 s32, w32;
  logic                        acc, err, row_done;
  logic [pru_pkg::PAD_W-1:0]   pad_mod, pad;

  // clamp registers to the supported range
  assign s32 = (scale_r == '0) ? 32'd1 :
               ((32'(scale_r) > 32'(MAX_SCALE)) ? 32'(MAX_SCALE) : 32'(scale_r));
  assign w32 = (width_r == '0) ? 32'd1 :
               ((32'(width_r) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(width_r));
  assign scale_cnt = s32[SW-1:0];

  assign pad_mod = 2'(w32[1:0] * s32[1:0] * 2'd3);
  assign pad     = 2'(2'd0 - pad_mod);

  assign in_ready = !cmd_v_r || cmd_take;
  assign acc      = in_valid && in_ready;
  assign err      = (in_func != phase_r);
  assign row_done = (32'(column_r) + 32'd1) >= w32;

  assign mem_addr  = column_r;
  assign mem_wdata = in_rgb;
  assign mem_we    = acc && !err && !in_func;
  assign mem_re    = acc && !err && in_func;

  always_comb begin
    column_nxt = column_r;
    rep_nxt    = rep_r;
    phase_nxt  = phase_r;
    cmd_v_nxt  = cmd_v_r;
    if (acc) begin
      cmd_v_nxt = 1'b1;
    end else if (cmd_take) begin
      cmd_v_nxt = 1'b0;
    end
    if (cfg_we) begin
      column_nxt = '0;
      rep_nxt    = '0;
      phase_nxt  = 1'b0;
    end else if (acc && !err) begin
      if (row_done) begin
        column_nxt = '0;
        if (!phase_r) begin
          rep_nxt   = '0;
          phase_nxt = (s32 > 32'd1);
        end else if ((32'(rep_r) + 32'd1) >= (s32 - 32'd1)) begin
          rep_nxt   = '0;
          phase_nxt = 1'b0;
        end else begin
          rep_nxt = rep_r + RW'(1);
        end
      end else begin
        column_nxt = column_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= pru_pkg::SCALE_W'(1);
      width_r  <= pru_pkg::WIDTH_W'(1);
      column_r <= '0;
      rep_r    <= '0;
      phase_r  <= 1'b0;
      cmd_v_r  <= 1'b0;
    end else begin
      column_r <= column_nxt;
      rep_r    <= rep_nxt;
      phase_r  <= phase_nxt;
      cmd_v_r  <= cmd_v_nxt;
      if (cfg_we) begin
        if (cfg_index == pru_pkg::REG_SCALE) begin
          scale_r <= cfg_wdata[pru_pkg::SCALE_W-1:0];
        end else begin
          width_r <= cfg_wdata[pru_pkg::WIDTH_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r.err      <= err;
      cmd_r.use_mem  <= in_func;
      cmd_r.row_done <= row_done;
      cmd_r.pad      <= row_done ? pad : '0;
      cmd_r.rgb      <= in_rgb;
    end
  end

  assign cmd_v = cmd_v_r;
  assign cmd   = cmd_r;

endmodule

// ----- src/pru_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_emit
// Expands each command into its result beats (copies, then pad bytes, or one
// error beat) and holds them in the output register.
// ----------------------------------------------------------------------------
module pru_emit #(
  parameter int SW = $clog2(pru_pkg::MAX_SCALE + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [SW-1:0]             scale_cnt,
  input  logic                      cmd_v,
  input  pru_pkg::cmd_t             cmd,
  input  logic [pru_pkg::PIX_W-1:0] mem_rdata,
  output logic                      cmd_take,
  output logic                      out_valid,
  input  logic                      out_ready,
  output pru_pkg::result_t          out_res
);

  logic                      em_v_r, em_v_nxt;
  logic                      em_err_r, em_row_r;
  logic [pru_pkg::PIX_W-1:0] em_rgb_r;
  logic [SW-1:0]             cp_r, cp_nxt;
  logic [pru_pkg::PAD_W-1:0] pd_r, pd_nxt;
  logic                      out_v_r, out_v_nxt;
  pru_pkg::result_t          out_r, res;
  logic                      step, final_beat;

  assign step = em_v_r && (!out_v_r || out_ready);

  always_comb begin
    res = '0;
    final_beat = 1'b0;
    priority if (em_err_r) begin
      res.error  = 1'b1;
      final_beat = 1'b1;
    end else if (cp_r != '0) begin
      res.rgb     = em_rgb_r;
      final_beat  = (cp_r == SW'(1)) && (pd_r == '0);
      res.row_end = final_beat && em_row_r;
    end else begin
      res.kind    = 1'b1;
      final_beat  = (pd_r == pru_pkg::PAD_W'(1));
      res.row_end = final_beat;
    end
    res.last = final_beat;
  end

  assign cmd_take = cmd_v && (!em_v_r || (step && final_beat));

  always_comb begin
    em_v_nxt  = em_v_r;
    cp_nxt    = cp_r;
    pd_nxt    = pd_r;
    out_v_nxt = out_v_r;
    if (cmd_take) begin
      em_v_nxt = 1'b1;
      cp_nxt   = scale_cnt;
      pd_nxt   = cmd.pad;
    end else if (step && final_beat) begin
      em_v_nxt = 1'b0;
    end else if (step) begin
      if (cp_r != '0) begin
        cp_nxt = cp_r - SW'(1);
      end else begin
        pd_nxt = pd_r - pru_pkg::PAD_W'(1);
      end
    end
    if (step) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      cp_r    <= '0;
      pd_r    <= '0;
    end else begin
      em_v_r  <= em_v_nxt;
      out_v_r <= out_v_nxt;
      cp_r    <= cp_nxt;
      pd_r    <= pd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      em_err_r <= cmd.err;
      em_row_r <= cmd.row_done;
      em_rgb_r <= cmd.use_mem ? mem_rdata : cmd.rgb;
    end
    if (step) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

endmodule

// ----- src/pixel_replicate_upscaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_replicate_upscaler
// Integer nearest-neighbor upscaler for rows of 24-bit pixels.
//
// in_ch carries items: func 0 loads a source pixel into the line store,
// func 1 replays the next stored pixel. out_ch carries one beat per output
// pixel, pad byte or error. Each accepted item gives scale pixel beats, plus
// 0..3 pad beats at the end of a row; an out-of-order item gives one error
// beat. cfg_we/cfg_index/cfg_wdata write scale (0) or source_width (1) and
// restart the row; write only while idle.
// An accepted item is registered in the command stage, then in the emitter,
// which sends one beat per cycle into the output register while out_ch is
// ready; the line store does at most one access per item.
// in_ch takes one item ahead of the one being expanded, then holds ready low
// until the emitter picks that item up on the last beat of the current one.
// Reset (synchronous, rst_n low) sets scale and width to 1 and the row to
// its start; the line store is not cleared. When out_ch stalls, the beat
// holds and in_ch deasserts ready once the command stage is full.
// ----------------------------------------------------------------------------
module pixel_replicate_upscaler #(
  parameter int MAX_WIDTH = pru_pkg::MAX_WIDTH,
  parameter int MAX_SCALE = pru_pkg::MAX_SCALE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pru_pkg::CFG_DATA_W-1:0] cfg_wdata,
  pru_in_if.sink                         in_ch,
  pru_out_if.source                      out_ch
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SW = $clog2(MAX_SCALE + 1);

  logic                      mem_we, mem_re;
  logic [CW-1:0]             mem_addr;
  logic [pru_pkg::PIX_W-1:0] mem_wdata, mem_rdata;
  logic [SW-1:0]             scale_cnt;
  logic                      cmd_v, cmd_take;
  pru_pkg::cmd_t             cmd;
  pru_pkg::result_t          res;

  pru_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE),
    .CW        (CW),
    .SW        (SW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_func   (in_ch.func),
    .in_rgb    ({in_ch.red, in_ch.green, in_ch.blue}),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .scale_cnt (scale_cnt),
    .cmd_v     (cmd_v),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  pru_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  pru_emit #(
    .SW (SW)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .scale_cnt (scale_cnt),
    .cmd_v     (cmd_v),
    .cmd       (cmd),
    .mem_rdata (mem_rdata),
    .cmd_take  (cmd_take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.kind      = res.kind;
  assign out_ch.out_red   = res.rgb[23:16];
  assign out_ch.out_green = res.rgb[15:8];
  assign out_ch.out_blue  = res.rgb[7:0];
  assign out_ch.row_end   = res.row_end;
  assign out_ch.error     = res.error;
  assign out_ch.last      = res.last;

endmodule

// ----- src/pru_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_checker
// Port-level checks on the upscaler result stream, bound to the top level.
// ----------------------------------------------------------------------------
module pru_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        kind,
  input logic [pru_pkg::COLOR_W-1:0] out_red,
  input logic [pru_pkg::COLOR_W-1:0] out_green,
  input logic [pru_pkg::COLOR_W-1:0] out_blue,
  input logic                        row_end,
  input logic                        error,
  input logic                        last
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({kind, out_red, out_green, out_blue,
                                                      row_end, error, last}))
    else $error("stalled result beat changed");

  a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error |-> last && !kind && !row_end &&
                           out_red == '0 && out_green == '0 && out_blue == '0)
    else $error("malformed error beat");

  a_pad_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind |-> !error && out_red == '0 && out_green == '0 && out_blue == '0)
    else $error("pad beat carries pixel data");

  a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && row_end |-> last)
    else $error("row end not on the final beat of an item");

endmodule

bind pixel_replicate_upscaler pru_checker u_pru_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .kind      (out_ch.kind),
  .out_red   (out_ch.out_red),
  .out_green (out_ch.out_green),
  .out_blue  (out_ch.out_blue),
  .row_end   (out_ch.row_end),
  .error     (out_ch.error),
  .last      (out_ch.last)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the pixel replicate upscaler. A directed table covers reset
// values, out-of-order items, scale and width clamping, pad counts and the
// replay cycle. Random phases then reconfigure the block and send mostly
// well-formed load/replay rows. The last phase sends a short burst at the
// widest width setting. Every output beat is checked against an in-bench
// model of the line store and row sequencing, with random idling on both
// channels in the directed table and the earlier random phases.
// ----------------------------------------------------------------------------
module tb;

  typedef enum bit {FUNC_PIXEL = 1'b0, FUNC_REPLAY = 1'b1} func_e;
  typedef enum bit {KIND_PIXEL = 1'b0, KIND_PAD = 1'b1} kind_e;
  typedef enum bit {ROW_CFG = 1'b0, ROW_ITEM = 1'b1} row_op_e;
  typedef enum int {IDLE_TX_LIGHT = 0, IDLE_RX_LIGHT = 1, IDLE_NONE = 2} idle_e;

  localparam int DW = pru_pkg::CFG_DATA_W;
  localparam int PW = pru_pkg::PIX_W;
  localparam int HW = pru_pkg::CFG_DATA_W - pru_pkg::SCALE_W;
  localparam int AW = $clog2(pru_pkg::MAX_WIDTH);

  typedef struct {
    row_op_e           op;
    pru_pkg::cfg_reg_t reg_idx;
    logic [DW-1:0]     wdata;
    func_e             func;
    logic [PW-1:0]     rgb;
    bit                typed;
    pru_pkg::result_t  want;
  } stim_row_t;

  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 180;
  localparam int WIDE_ITEMS    = 8;

  bit clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [pru_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [DW-1:0] cfg_wdata;

  pru_in_if  in_ch ();
  pru_out_if out_ch ();

  pixel_replicate_upscaler DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model state
  logic [PW-1:0]                   line_mem [pru_pkg::MAX_WIDTH];
  int unsigned                     col;
  int unsigned                     rep;
  func_e                           row_phase;
  logic [pru_pkg::SCALE_W-1:0]     scale_reg;
  logic [pru_pkg::WIDTH_W-1:0]     width_reg;

  pru_pkg::result_t item_beats [$];
  pru_pkg::result_t want_beats [$];
  stim_row_t        table_rows [$];

  int fault_count = 0;
  int tx_gap_pct  = 0;
  int rx_stall_pct = 0;

  function automatic pru_pkg::result_t make_beat(kind_e kind, logic [PW-1:0] rgb,
                                                 bit row_end, bit err, bit last);
    pru_pkg::result_t b;
    b.kind    = kind;
    b.rgb     = rgb;
    b.row_end = row_end;
    b.error   = err;
    b.last    = last;
    return b;
  endfunction

  function automatic int unsigned eff_scale();
    if (scale_reg == '0) return 1;
    if (32'(scale_reg) > pru_pkg::MAX_SCALE) return pru_pkg::MAX_SCALE;
    return 32'(scale_reg);
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == '0) return 1;
    if (32'(width_reg) > pru_pkg::MAX_WIDTH) return pru_pkg::MAX_WIDTH;
    return 32'(width_reg);
  endfunction

  // beats caused by one item, left in item_beats; updates the row state
  task automatic upscale_item(func_e func, logic [PW-1:0] rgb);
    int unsigned s;
    int unsigned w;
    int unsigned pad;
    bit done;
    logic [PW-1:0] pix;
    pru_pkg::result_t b;
    s = eff_scale();
    w = eff_width();
    item_beats.delete();
    if (func != row_phase) begin
      item_beats.push_back(make_beat(KIND_PIXEL, '0, 1'b0, 1'b1, 1'b1));
      return;
    end
    if (col >= w) col = 0;
    if (func == FUNC_PIXEL) begin
      line_mem[AW'(col)] = rgb;
      pix = rgb;
    end else begin
      pix = line_mem[AW'(col)];
    end
    done = (col + 1 >= w);
    pad = (4 - ((w * s * 3) & 3)) & 3;
    for (int i = 0; i < s; i++) item_beats.push_back(make_beat(KIND_PIXEL, pix, 0, 0, 0));
    if (done) begin
      for (int i = 0; i < pad; i++) item_beats.push_back(make_beat(KIND_PAD, '0, 0, 0, 0));
      b = item_beats.pop_back();
      b.row_end = 1'b1;
      item_beats.push_back(b);
      col = 0;
      if (row_phase == FUNC_PIXEL) begin
        rep = 0;
        row_phase = (s > 1) ? FUNC_REPLAY : FUNC_PIXEL;
      end else begin
        rep++;
        if (rep >= s - 1) begin
          rep = 0;
          row_phase = FUNC_PIXEL;
        end
      end
    end else begin
      col++;
    end
    b = item_beats.pop_back();
    b.last = 1'b1;
    item_beats.push_back(b);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (want_beats.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(pru_pkg::cfg_reg_t idx, logic [DW-1:0] data);
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == pru_pkg::REG_SCALE) scale_reg = data[pru_pkg::SCALE_W-1:0];
    else width_reg = data[pru_pkg::WIDTH_W-1:0];
    col = 0;
    rep = 0;
    row_phase = FUNC_PIXEL;
  endtask

  // called at a falling edge; returns at the falling edge after the item is accepted
  task automatic send_item(func_e func, logic [PW-1:0] rgb, bit typed,
                           pru_pkg::result_t want);
    while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    upscale_item(func, rgb);
    if (typed) want_beats.push_back(want);
    else foreach (item_beats[i]) want_beats.push_back(item_beats[i]);
    in_ch.valid <= 1'b1;
    in_ch.func  <= func;
    in_ch.red   <= rgb[23:16];
    in_ch.green <= rgb[15:8];
    in_ch.blue  <= rgb[7:0];
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic set_idle(idle_e mode);
    case (mode)
      IDLE_TX_LIGHT: begin
        tx_gap_pct   = 8;
        rx_stall_pct = 49;
      end
      IDLE_RX_LIGHT: begin
        tx_gap_pct   = 49;
        rx_stall_pct = 8;
      end
      default: begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
    endcase
  endtask

  task automatic add_cfg(pru_pkg::cfg_reg_t idx, logic [DW-1:0] data);
    stim_row_t r;
    r.op      = ROW_CFG;
    r.reg_idx = idx;
    r.wdata   = data;
    r.func    = FUNC_PIXEL;
    r.rgb     = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    table_rows.push_back(r);
  endtask

  task automatic add_item(func_e func, logic [PW-1:0] rgb, bit typed,
                          pru_pkg::result_t want);
    stim_row_t r;
    r.op      = ROW_ITEM;
    r.reg_idx = pru_pkg::REG_SCALE;
    r.wdata   = '0;
    r.func    = func;
    r.rgb     = rgb;
    r.typed   = typed;
    r.want    = want;
    table_rows.push_back(r);
  endtask

  // receiver
  always @(negedge clk) begin
    out_ch.ready <= (rx_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= rx_stall_pct);
  end

  // output checker
  always @(posedge clk) begin
    pru_pkg::result_t got;
    pru_pkg::result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.kind    = out_ch.kind;
      got.rgb     = {out_ch.out_red, out_ch.out_green, out_ch.out_blue};
      got.row_end = out_ch.row_end;
      got.error   = out_ch.error;
      got.last    = out_ch.last;
      if (want_beats.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected beat: kind=%0b rgb=%06h row_end=%0b error=%0b last=%0b",
                   got.kind, got.rgb, got.row_end, got.error, got.last);
      end else begin
        want = want_beats.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch: want kind=%0b rgb=%06h row_end=%0b error=%0b last=%0b",
                     want.kind, want.rgb, want.row_end, want.error, want.last);
            $display("          got  kind=%0b rgb=%06h row_end=%0b error=%0b last=%0b",
                     got.kind, got.rgb, got.row_end, got.error, got.last);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    int rand_items;
    int n_items;
    int unsigned s_eff;
    int unsigned w_eff;
    logic [DW-1:0] s_data;
    logic [DW-1:0] w_data;
    func_e f;
    int pick;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = pru_pkg::REG_SCALE;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.func   = FUNC_PIXEL;
    in_ch.red    = '0;
    in_ch.green  = '0;
    in_ch.blue   = '0;

    scale_reg = pru_pkg::SCALE_W'(1);
    width_reg = pru_pkg::WIDTH_W'(1);
    col       = 0;
    rep       = 0;
    row_phase = FUNC_PIXEL;
    foreach (line_mem[i]) line_mem[i] = '0;

    // directed table
    add_item(FUNC_REPLAY, 24'h5a5a5a, 1, make_beat(KIND_PIXEL, '0, 0, 1, 1));
    add_item(FUNC_PIXEL,  24'hff0080, 0, '0);
    add_cfg(pru_pkg::REG_WIDTH, 11'd4);
    add_item(FUNC_PIXEL,  24'h000000, 1, make_beat(KIND_PIXEL, 24'h000000, 0, 0, 1));
    add_item(FUNC_PIXEL,  24'hffffff, 1, make_beat(KIND_PIXEL, 24'hffffff, 0, 0, 1));
    add_item(FUNC_PIXEL,  24'h123456, 0, '0);
    add_item(FUNC_PIXEL,  24'ha5c30f, 1, make_beat(KIND_PIXEL, 24'ha5c30f, 1, 0, 1));
    add_cfg(pru_pkg::REG_SCALE, 11'd2);
    add_item(FUNC_PIXEL,  24'h010203, 0, '0);
    add_item(FUNC_PIXEL,  24'hfefdfc, 0, '0);
    add_item(FUNC_PIXEL,  24'h80007f, 0, '0);
    add_item(FUNC_PIXEL,  24'h3c3c3c, 0, '0);
    add_item(FUNC_PIXEL,  24'h777777, 1, make_beat(KIND_PIXEL, '0, 0, 1, 1));
    for (int i = 0; i < 4; i++) add_item(FUNC_REPLAY, 24'h000000, 0, '0);
    add_item(FUNC_REPLAY, 24'hffffff, 1, make_beat(KIND_PIXEL, '0, 0, 1, 1));
    add_cfg(pru_pkg::REG_SCALE, 11'd0);
    add_cfg(pru_pkg::REG_WIDTH, 11'd0);
    add_item(FUNC_PIXEL,  24'h800001, 0, '0);
    add_cfg(pru_pkg::REG_SCALE, 11'h7ff);
    add_cfg(pru_pkg::REG_WIDTH, 11'd1);
    add_item(FUNC_PIXEL,  24'hc0ffee, 0, '0);
    add_item(FUNC_REPLAY, 24'h000000, 0, '0);
    add_cfg(pru_pkg::REG_SCALE, 11'd15);
    add_item(FUNC_PIXEL,  24'h0f0f0f, 0, '0);
    add_item(FUNC_REPLAY, 24'h000000, 0, '0);
    add_cfg(pru_pkg::REG_SCALE, 11'd17);
    add_item(FUNC_PIXEL,  24'hf0f0f0, 0, '0);

    set_idle(IDLE_TX_LIGHT);
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (table_rows[i]) begin
      if (table_rows[i].op == ROW_CFG)
        write_reg(table_rows[i].reg_idx, table_rows[i].wdata);
      else
        send_item(table_rows[i].func, table_rows[i].rgb, table_rows[i].typed,
                  table_rows[i].want);
    end

    // random phases
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      set_idle(idle_e'(rand_items * 3 / RANDOM_ITEMS));
      pick = $urandom_range(99);
      if (pick < 60)      s_data = DW'($urandom_range(4, 1));
      else if (pick < 70) s_data = '0;
      else if (pick < 80) s_data = DW'($urandom_range(16, 15));
      else                s_data = DW'($urandom_range(31, 0));
      s_data[DW-1:pru_pkg::SCALE_W] = HW'($urandom);
      pick = $urandom_range(99);
      if (pick < 70)      w_data = DW'($urandom_range(6, 1));
      else if (pick < 80) w_data = '0;
      else                w_data = DW'($urandom);
      if ($urandom_range(1)) begin
        write_reg(pru_pkg::REG_SCALE, s_data);
        write_reg(pru_pkg::REG_WIDTH, w_data);
      end else begin
        write_reg(pru_pkg::REG_WIDTH, w_data);
        write_reg(pru_pkg::REG_SCALE, s_data);
      end
      s_eff = eff_scale();
      w_eff = eff_width();
      if (s_eff * w_eff <= 36) n_items = int'(s_eff * w_eff + $urandom_range(3, 0));
      else n_items = int'($urandom_range(30, 10));
      for (int i = 0; i < n_items && rand_items < RANDOM_ITEMS; i++) begin
        if (rand_items == RANDOM_ITEMS / 2 || $urandom_range(39) == 0) wait_drain();
        f = ($urandom_range(99) < 92) ? row_phase : func_e'(~row_phase);
        send_item(f, PW'($urandom), 1'b0, '0);
        rand_items++;
      end
    end

    // short burst at the widest width setting
    set_idle(IDLE_NONE);
    write_reg(pru_pkg::REG_WIDTH, 11'h7ff);
    write_reg(pru_pkg::REG_SCALE, 11'h7e1);
    for (int i = 0; i < WIDE_ITEMS; i++) send_item(FUNC_PIXEL, PW'($urandom), 1'b0, '0);
    send_item(FUNC_REPLAY, PW'($urandom), 1'b0, '0);

    wait_drain();
    repeat (40) @(negedge clk);
    if (fault_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/pru_pkg.sv
src/pru_if.sv
src/pru_line_store.sv
src/pru_ctrl.sv
src/pru_emit.sv
src/pixel_replicate_upscaler.sv
src/pru_checker.sv
verif/tb.sv
